FILE: rtl/lgs_pkg.sv
package lgs_pkg;

  localparam int COL_W              = 64;
  localparam int HEIGHT_W           = 7;
  localparam int MAX_HEIGHT_DEFAULT = 64;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;
  localparam int NCOUNT_W           = 4;
  localparam int QUEUE_DEPTH        = 4;

  typedef struct packed {
    logic [COL_W-1:0] column_bits;
    logic             final_column;
  } column_t;

  typedef struct packed {
    logic [COL_W-1:0] next_bits;
    logic             last_result;
  } result_t;

  // Bits one row of the board hands to the rows next to it
  typedef struct packed {
    logic left;
    logic middle;
    logic incoming;
  } cell_bits_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

  function automatic logic life_rule(input logic [NCOUNT_W-1:0] n, input logic alive);
    return (n == NCOUNT_W'(3)) || (alive && (n == NCOUNT_W'(2)));
  endfunction

endpackage

FILE: rtl/lgs_cell.sv
module lgs_cell (
  input  logic               clk,
  input  logic               rst,
  input  lgs_pkg::cell_ctrl_t ctrl,
  input  logic               incoming,
  input  logic               mask,
  input  lgs_pkg::cell_bits_t below,
  input  lgs_pkg::cell_bits_t above,
  output logic               left,
  output logic               middle,
  output logic               gen_a,
  output logic               gen_b
);
  import lgs_pkg::*;

  logic [NCOUNT_W-1:0] n_a;
  logic [NCOUNT_W-1:0] n_b;

  always_ff @(posedge clk) begin
    if (rst || (ctrl.advance && ctrl.clear)) begin
      left   <= 1'b0;
      middle <= 1'b0;
    end else if (ctrl.advance) begin
      left   <= middle;
      middle <= incoming;
    end
  end

  // gen_a: next generation of the middle row bit, new column on the right.
  // gen_b: next generation of the incoming bit with a dead column beyond it.
  always_comb begin
    n_a = NCOUNT_W'(below.left) + NCOUNT_W'(left) + NCOUNT_W'(above.left)
        + NCOUNT_W'(below.middle) + NCOUNT_W'(above.middle)
        + NCOUNT_W'(below.incoming) + NCOUNT_W'(incoming) + NCOUNT_W'(above.incoming);
    n_b = NCOUNT_W'(below.middle) + NCOUNT_W'(middle) + NCOUNT_W'(above.middle)
        + NCOUNT_W'(below.incoming) + NCOUNT_W'(above.incoming);
  end

  assign gen_a = mask & life_rule(n_a, middle);
  assign gen_b = mask & life_rule(n_b, incoming);

endmodule

FILE: rtl/lgs_result_queue.sv
module lgs_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  lgs_pkg::result_t push_first,
  input  lgs_pkg::result_t push_second,
  output logic             space,
  output logic             res_valid,
  input  logic             res_ready,
  output lgs_pkg::result_t res
);
  import lgs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_1;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = res_valid & res_ready;
  assign wr_ptr_1  = wr_ptr + PTR_W'(1);
  assign res_valid = (count != '0);
  assign res       = entries[rd_ptr];
  // keep room for the two results a final column can bring
  assign space     = (count <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((push_n != 2'd0) && (PTR_W'(i) == wr_ptr)) begin
        entries[i] <= push_first;
      end else if ((push_n == 2'd2) && (PTR_W'(i) == wr_ptr_1)) begin
        entries[i] <= push_second;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue count beyond depth");

  a_push_needs_space: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> space)
    else $error("results pushed without room");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (pop && (push_n == 2'd0)) |=> (count == $past(count) - CNT_W'(1)))
    else $error("result queue count did not drop on pop");

endmodule

FILE: rtl/life_generation_step.sv
// One generation of the B3/S23 automaton on a board streamed one column per
// request, bit y of a column being cell y. Cells off the board are dead, and
// bits at or above board_height are cleared on the way in and out. Every
// column but the first returns the next generation of the column before it;
// the final column also returns its own, flagged last_result, and the block
// then starts a fresh board. A row of MAX_HEIGHT cells holds the two stored
// columns, one bit of each per cell, and computes all rows in parallel, so
// a column is taken every cycle while the queue has room. Results pass
// through a four-entry queue; a final column puts up to two results in it,
// and intake pauses only when fewer than two queue slots are free. The user
// writes board_height only while no results are outstanding; not enforced.
module life_generation_step #(
  parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            col_valid,
  output logic                            col_ready,
  input  lgs_pkg::column_t                col,
  output logic                            res_valid,
  input  logic                            res_ready,
  output lgs_pkg::result_t                res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lgs_pkg::HEIGHT_W-1:0]    cfg_data
);
  import lgs_pkg::*;

  logic [HEIGHT_W-1:0] board_height;
  logic                middle_valid;
  logic                accept;
  logic                space;
  cell_ctrl_t          ctrl;

  logic [COL_W-1:0]    mask_vec;
  logic [COL_W-1:0]    inc_vec;
  logic [COL_W-1:0]    left_vec;
  logic [COL_W-1:0]    mid_vec;
  logic [COL_W-1:0]    gen_a;
  logic [COL_W-1:0]    gen_b;
  logic [COL_W+1:0]    inc_pad;
  logic [COL_W+1:0]    left_pad;
  logic [COL_W+1:0]    mid_pad;

  logic [1:0]          push_n;
  result_t             res_a;
  result_t             res_b;
  result_t             push_first;

  assign cfg_ready = 1'b1;
  assign col_ready = space;
  assign accept    = col_valid & col_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_height <= HEIGHT_RESET;
      middle_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        board_height <= cfg_data;
      end
      if (accept) begin
        middle_valid <= !col.final_column;
      end
    end
  end

  assign ctrl.advance = accept;
  assign ctrl.clear   = col.final_column;

  assign inc_vec  = col.column_bits & mask_vec;
  assign inc_pad  = {1'b0, inc_vec, 1'b0};
  assign left_pad = {1'b0, left_vec, 1'b0};
  assign mid_pad  = {1'b0, mid_vec, 1'b0};

  for (genvar y = 0; y < COL_W; y++) begin : g_row
    if (y < MAX_HEIGHT) begin : g_cell
      cell_bits_t below;
      cell_bits_t above;

      assign mask_vec[y] = (board_height > HEIGHT_W'(y));
      assign below = '{left: left_pad[y], middle: mid_pad[y], incoming: inc_pad[y]};
      assign above = '{left: left_pad[y+2], middle: mid_pad[y+2], incoming: inc_pad[y+2]};

      lgs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .incoming (inc_vec[y]),
        .mask     (mask_vec[y]),
        .below    (below),
        .above    (above),
        .left     (left_vec[y]),
        .middle   (mid_vec[y]),
        .gen_a    (gen_a[y]),
        .gen_b    (gen_b[y])
      );
    end else begin : g_empty
      assign mask_vec[y] = 1'b0;
      assign left_vec[y] = 1'b0;
      assign mid_vec[y]  = 1'b0;
      assign gen_a[y]    = 1'b0;
      assign gen_b[y]    = 1'b0;
    end
  end

  assign res_a      = '{next_bits: gen_a, last_result: 1'b0};
  assign res_b      = '{next_bits: gen_b, last_result: 1'b1};
  assign push_first = middle_valid ? res_a : res_b;
  assign push_n     = accept ? (2'(middle_valid) + 2'(col.final_column)) : 2'd0;

  lgs_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_n      (push_n),
    .push_first  (push_first),
    .push_second (res_b),
    .space       (space),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  a_empty_middle: assert property (@(posedge clk) disable iff (rst)
    !middle_valid |-> (mid_vec == '0) && (left_vec == '0))
    else $error("stored columns not clear while no column is held");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && col.final_column) |=> !middle_valid && (mid_vec == '0))
    else $error("final column did not clear the stored columns");

  a_hold_column: assert property (@(posedge clk) disable iff (rst)
    (accept && !col.final_column) |=> middle_valid && (mid_vec == $past(inc_vec)))
    else $error("column not held after a non-final request");

endmodule
